### rtl/assert_macros.svh
// Assertion helpers shared by the frame builder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define SCB_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define SCB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/scb_pkg.sv
package scb_pkg;

    // Register indexes of the configuration port.
    localparam logic CFG_IDX_W = 1'b0;
    localparam logic REG_MAX_FRAME_BYTES = 1'b0;
    localparam logic REG_START_BYTE      = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [8:0] MAX_FRAME_RESET  = 9'd258;
    localparam logic [7:0] START_BYTE_RESET = 8'd85;

    // Frame arithmetic.
    localparam logic [7:0] LEN_OVERHEAD   = 8'd3;
    localparam logic [8:0] FRAME_OVERHEAD = 9'd6;
    localparam logic [7:0] MAX_COUNT      = 8'd252;

    // Input action codes.
    localparam logic ACT_HEADER  = 1'b0;
    localparam logic ACT_PAYLOAD = 1'b1;

    // Depth of the job queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Byte positions inside one job.
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_SYNC_A   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_SYNC_B   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_ID       = 3'd2;
    localparam logic [STEP_W-1:0] STEP_LEN      = 3'd3;
    localparam logic [STEP_W-1:0] STEP_CMD      = 3'd4;
    localparam logic [STEP_W-1:0] STEP_HDR_CHK  = 3'd5;
    localparam logic [STEP_W-1:0] STEP_DATA     = 3'd0;
    localparam logic [STEP_W-1:0] STEP_DATA_CHK = 3'd1;
    localparam logic [STEP_W-1:0] STEP_REJECT   = 3'd0;

    typedef struct packed {
        logic       action;
        logic [7:0] servo_id;
        logic [7:0] command_code;
        logic [7:0] payload_count;
        logic [7:0] payload_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       status;
        logic       end_of_frame;
    } out_item_t;

    typedef enum logic [1:0] {
        JOB_HEADER,
        JOB_REJECT,
        JOB_PAYLOAD
    } job_kind_t;

    // One classified item, ready to be expanded into output bytes.
    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] data;      // servo id on a header, the byte on a payload
        logic [7:0] len;
        logic [7:0] cmd;
        logic [7:0] chk;
        logic       with_chk;  // the checksum byte closes this job
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } job_push_t;

endpackage

### rtl/scb_queue.sv
`include "assert_macros.svh"

module scb_queue #(
    parameter int DEPTH = scb_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  scb_pkg::job_push_t push,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output scb_pkg::job_t    head_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    scb_pkg::job_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = push.valid ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push.valid && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push.valid) begin
            mem[wr_ptr_reg] <= push.job;
        end
    end

    `SCB_ASSERT(a_no_overflow, aclk, aresetn, push.valid |-> !full, "job pushed into a full queue")
    `SCB_ASSERT(a_no_underflow, aclk, aresetn, pop |-> head_valid, "job popped from an empty queue")

endmodule

### rtl/scb_front.sv
module scb_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  scb_pkg::in_item_t   s_item,
    input  logic [8:0]          max_frame_bytes,
    input  logic                queue_full,
    output scb_pkg::job_push_t  push
);

    logic       frame_open_reg, frame_open_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] running_sum_reg, running_sum_next;

    logic       accept;
    logic [8:0] hdr_total;
    logic [7:0] hdr_len;
    logic [7:0] hdr_sum;
    logic       hdr_reject;
    logic [7:0] pay_sum;
    logic [7:0] pay_left;

    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;

    // Header checks and sums.
    assign hdr_total  = {1'b0, s_item.payload_count} + scb_pkg::FRAME_OVERHEAD;
    assign hdr_len    = s_item.payload_count + scb_pkg::LEN_OVERHEAD;
    assign hdr_sum    = s_item.servo_id + hdr_len + s_item.command_code;
    assign hdr_reject = (s_item.payload_count > scb_pkg::MAX_COUNT)
                        || (hdr_total > max_frame_bytes);

    // Payload bookkeeping.
    assign pay_sum  = running_sum_reg + s_item.payload_byte;
    assign pay_left = bytes_left_reg - 1'b1;

    // Classify the accepted item and update the frame state.
    always_comb begin
        frame_open_next  = frame_open_reg;
        bytes_left_next  = bytes_left_reg;
        running_sum_next = running_sum_reg;
        push.valid        = 1'b0;
        push.job.kind     = scb_pkg::JOB_HEADER;
        push.job.data     = s_item.servo_id;
        push.job.len      = hdr_len;
        push.job.cmd      = s_item.command_code;
        push.job.chk      = ~hdr_sum;
        push.job.with_chk = 1'b0;
        if (accept) begin
            if (s_item.action == scb_pkg::ACT_HEADER) begin
                // A new header abandons any open frame.
                frame_open_next  = 1'b0;
                bytes_left_next  = '0;
                running_sum_next = '0;
                push.valid       = 1'b1;
                if (hdr_reject) begin
                    push.job.kind = scb_pkg::JOB_REJECT;
                end else if (s_item.payload_count == '0) begin
                    push.job.with_chk = 1'b1;
                end else begin
                    frame_open_next  = 1'b1;
                    bytes_left_next  = s_item.payload_count;
                    running_sum_next = hdr_sum;
                end
            end else if (frame_open_reg) begin
                push.valid    = 1'b1;
                push.job.kind = scb_pkg::JOB_PAYLOAD;
                push.job.data = s_item.payload_byte;
                push.job.chk  = ~pay_sum;
                bytes_left_next  = pay_left;
                running_sum_next = pay_sum;
                if (pay_left == '0) begin
                    push.job.with_chk = 1'b1;
                    frame_open_next   = 1'b0;
                    running_sum_next  = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_open_reg  <= 1'b0;
            bytes_left_reg  <= '0;
            running_sum_reg <= '0;
        end else begin
            frame_open_reg  <= frame_open_next;
            bytes_left_reg  <= bytes_left_next;
            running_sum_reg <= running_sum_next;
        end
    end

endmodule

### rtl/scb_back.sv
`include "assert_macros.svh"

module scb_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  scb_pkg::job_t       head_data,
    output logic                pop,
    input  logic [7:0]          start_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output scb_pkg::out_item_t  m_item
);

    logic [scb_pkg::STEP_W-1:0] step_reg, step_next;
    logic [scb_pkg::STEP_W-1:0] last_step;
    logic                       m_valid_reg, m_valid_next;
    scb_pkg::out_item_t         m_item_reg, m_item_next;
    logic                       out_free;
    logic                       emit;

    assign out_free = !m_valid_reg || m_ready;
    assign emit     = head_valid && out_free;
    assign pop      = emit && (step_reg == last_step);
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    // Last byte position of the job at the queue head.
    always_comb begin
        unique case (head_data.kind)
            scb_pkg::JOB_HEADER:
                last_step = head_data.with_chk ? scb_pkg::STEP_HDR_CHK : scb_pkg::STEP_CMD;
            scb_pkg::JOB_PAYLOAD:
                last_step = head_data.with_chk ? scb_pkg::STEP_DATA_CHK : scb_pkg::STEP_DATA;
            default:
                last_step = scb_pkg::STEP_REJECT;
        endcase
    end

    // Select the byte for the current position of the head job.
    always_comb begin
        m_item_next.frame_byte   = head_data.chk;
        m_item_next.status       = 1'b0;
        m_item_next.end_of_frame = 1'b0;
        unique case (head_data.kind)
            scb_pkg::JOB_HEADER: begin
                unique case (step_reg)
                    scb_pkg::STEP_SYNC_A: m_item_next.frame_byte = start_byte;
                    scb_pkg::STEP_SYNC_B: m_item_next.frame_byte = start_byte;
                    scb_pkg::STEP_ID:     m_item_next.frame_byte = head_data.data;
                    scb_pkg::STEP_LEN:    m_item_next.frame_byte = head_data.len;
                    scb_pkg::STEP_CMD:    m_item_next.frame_byte = head_data.cmd;
                    default:              m_item_next.end_of_frame = 1'b1;
                endcase
            end
            scb_pkg::JOB_PAYLOAD: begin
                if (step_reg == scb_pkg::STEP_DATA) begin
                    m_item_next.frame_byte = head_data.data;
                end else begin
                    m_item_next.end_of_frame = 1'b1;
                end
            end
            default: begin
                m_item_next.frame_byte   = '0;
                m_item_next.status       = 1'b1;
                m_item_next.end_of_frame = 1'b1;
            end
        endcase
    end

    // Step counter and output register control.
    always_comb begin
        step_next    = step_reg;
        m_valid_next = m_valid_reg;
        if (out_free) begin
            m_valid_next = head_valid;
        end
        if (emit) begin
            step_next = (step_reg == last_step) ? '0 : step_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_item_reg <= m_item_next;
        end
    end

    `SCB_ASSERT(a_step_in_range, aclk, aresetn, head_valid |-> step_reg <= last_step, "byte position past the end of the job")
    `SCB_ASSERT(a_job_held_midway, aclk, aresetn, (step_reg != '0) |-> head_valid, "job left the queue before its last byte")
    `SCB_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> (!m_valid_reg && step_reg == '0), "output or step not cleared by reset")

endmodule

### rtl/servo_command_frame_builder_core.sv
// Servo bus command frame builder. Header items (action 0) open a frame and
// payload items (action 1) supply its parameter bytes; results come out one
// frame byte per transfer: start byte twice, id, length (count + 3), command,
// the payload bytes, then the inverted 8-bit checksum with end_of_frame set.
// A header whose frame (count + 6 bytes) exceeds max_frame_bytes, or whose
// count is above 252, gives a single result with status and end_of_frame set
// and frame_byte zero; its payload items are then dropped without a result.
// The input side takes one item per cycle while the job queue (QUEUE_DEPTH
// entries) has room, so it keeps accepting while results wait downstream.
// The output byte sequencer emits one byte per cycle unless m_ready stalls
// it, which sets the rate: a header gives 5 bytes (6 with no payload), a
// payload item 1 (2 for the last one, which carries the checksum), a
// rejection 1, and an ignored payload item none. Write the configuration
// registers only while no frame bytes are in flight.
module servo_command_frame_builder_core #(
    parameter int QUEUE_DEPTH = scb_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  scb_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output scb_pkg::out_item_t  m_item,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [8:0]          cfg_wdata
);

    logic [8:0]         max_frame_bytes_reg;
    logic [7:0]         start_byte_reg;
    scb_pkg::job_push_t push;
    logic               queue_full;
    logic               pop;
    logic               head_valid;
    scb_pkg::job_t      head_data;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_frame_bytes_reg <= scb_pkg::MAX_FRAME_RESET;
            start_byte_reg      <= scb_pkg::START_BYTE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                scb_pkg::REG_MAX_FRAME_BYTES: max_frame_bytes_reg <= cfg_wdata;
                scb_pkg::REG_START_BYTE:      start_byte_reg      <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    scb_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_item          (s_item),
        .max_frame_bytes (max_frame_bytes_reg),
        .queue_full      (queue_full),
        .push            (push)
    );

    scb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    scb_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .start_byte (start_byte_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule
